// File: hw/rtl/two_button_gesture_recognizer_defines.svh
`ifndef TWO_BUTTON_GESTURE_RECOGNIZER_DEFINES_SVH
`define TWO_BUTTON_GESTURE_RECOGNIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TBGR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, checked outside reset
`define TBGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/tbgr_pkg.sv
`default_nettype none

package tbgr_pkg;

    localparam int TICK_COUNT_BITS = 10;
    localparam int SIMUL_BITS      = 8;
    localparam int HOLD_BITS       = 10;
    localparam int DOUBLE_BITS     = 8;
    localparam int CMP_BITS        = (TICK_COUNT_BITS > HOLD_BITS) ? TICK_COUNT_BITS : HOLD_BITS;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = HOLD_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SIMUL_TICKS  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TICKS   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_TICKS = 2'd2;

    localparam logic [SIMUL_BITS-1:0]  SIMUL_RESET  = 8'd8;
    localparam logic [HOLD_BITS-1:0]   HOLD_RESET   = 10'd134;
    localparam logic [DOUBLE_BITS-1:0] DOUBLE_RESET = 8'd20;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_PRESSED = 3'b010,
        PH_WAIT    = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        GEST_L_SINGLE   = 3'd0,
        GEST_L_DOUBLE   = 3'd1,
        GEST_L_HOLD     = 3'd2,
        GEST_R_SINGLE   = 3'd3,
        GEST_R_DOUBLE   = 3'd4,
        GEST_R_HOLD     = 3'd5,
        GEST_BOTH_PRESS = 3'd6,
        GEST_BOTH_HOLD  = 3'd7
    } gesture_t;

    typedef struct packed {
        logic [SIMUL_BITS-1:0]  simul_ticks;
        logic [HOLD_BITS-1:0]   hold_ticks;
        logic [DOUBLE_BITS-1:0] double_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t                     phase;
        logic [TICK_COUNT_BITS-1:0] elapsed;
        logic                       left_involved;
        logic                       right_involved;
        logic                       left_consumed;
        logic                       right_consumed;
        logic                       hold_reported;
        logic                       left_single_waiting;
        logic                       right_single_waiting;
    } state_t;

    // up to two gestures caused by one tick, g0 first
    typedef struct packed {
        logic [1:0] cnt;
        gesture_t   g0;
        gesture_t   g1;
    } res_t;

    function automatic res_t put_gesture(res_t r, gesture_t g);
        res_t o;
        o = r;
        if (r.cnt == 2'd0)
        begin
            o.g0 = g;
        end
        else
        begin
            o.g1 = g;
        end
        o.cnt = r.cnt + 2'd1;
        return o;
    endfunction

    function automatic state_t end_gesture(state_t s);
        state_t o;
        o = s;
        o.phase          = PH_IDLE;
        o.left_involved  = 1'b0;
        o.right_involved = 1'b0;
        o.left_consumed  = 1'b0;
        o.right_consumed = 1'b0;
        o.hold_reported  = 1'b0;
        return o;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tbgr_step.sv
`default_nettype none

// next state and gestures for one sampling tick
module tbgr_step
(
    input  tbgr_pkg::state_t cur,
    input  tbgr_pkg::cfg_t   cfg,
    input  logic             left_pressed,
    input  logic             right_pressed,
    output tbgr_pkg::state_t nxt,
    output tbgr_pkg::res_t   res
);

    logic                                 btn_down;
    logic                                 do_start;
    logic [tbgr_pkg::TICK_COUNT_BITS-1:0] el_inc;
    logic [tbgr_pkg::CMP_BITS-1:0]        el_cmp;
    tbgr_pkg::state_t                     s;
    tbgr_pkg::res_t                       r;

    assign btn_down = left_pressed | right_pressed;
    // saturating tick count
    assign el_inc = (cur.elapsed == '1) ? cur.elapsed
                                        : tbgr_pkg::TICK_COUNT_BITS'(cur.elapsed + 1'b1);
    assign el_cmp = tbgr_pkg::CMP_BITS'(el_inc);

    always_comb
    begin
        s        = cur;
        r        = '{cnt: 2'd0, g0: tbgr_pkg::GEST_L_SINGLE, g1: tbgr_pkg::GEST_L_SINGLE};
        do_start = 1'b0;
        unique case (cur.phase)
            tbgr_pkg::PH_PRESSED:
            begin
                s.elapsed = el_inc;
                if (el_cmp <= tbgr_pkg::CMP_BITS'(cfg.simul_ticks))
                begin
                    if (left_pressed && !cur.left_consumed)
                    begin
                        s.left_involved = 1'b1;
                    end
                    if (right_pressed && !cur.right_consumed)
                    begin
                        s.right_involved = 1'b1;
                    end
                end
                if (btn_down)
                begin
                    if (!cur.hold_reported && el_cmp >= tbgr_pkg::CMP_BITS'(cfg.hold_ticks))
                    begin
                        s.hold_reported = 1'b1;
                        if (s.left_involved && s.right_involved)
                        begin
                            r = tbgr_pkg::put_gesture(r, tbgr_pkg::GEST_BOTH_HOLD);
                        end
                        else if (s.left_involved)
                        begin
                            r = tbgr_pkg::put_gesture(r, tbgr_pkg::GEST_L_HOLD);
                        end
                        else if (s.right_involved)
                        begin
                            r = tbgr_pkg::put_gesture(r, tbgr_pkg::GEST_R_HOLD);
                        end
                    end
                end
                else if (cur.hold_reported)
                begin
                    s = tbgr_pkg::end_gesture(s);
                end
                else if (s.left_involved && s.right_involved)
                begin
                    r = tbgr_pkg::put_gesture(r, tbgr_pkg::GEST_BOTH_PRESS);
                    s = tbgr_pkg::end_gesture(s);
                end
                else
                begin
                    s.left_single_waiting  = cur.left_single_waiting | s.left_involved;
                    s.right_single_waiting = cur.right_single_waiting | s.right_involved;
                    s.phase                = tbgr_pkg::PH_WAIT;
                    s.elapsed              = '0;
                    s.left_involved        = 1'b0;
                    s.right_involved       = 1'b0;
                end
            end
            tbgr_pkg::PH_WAIT:
            begin
                if (btn_down)
                begin
                    do_start = 1'b1;
                end
                else
                begin
                    s.elapsed = el_inc;
                    if (el_cmp >= tbgr_pkg::CMP_BITS'(cfg.double_ticks))
                    begin
                        if (cur.left_single_waiting)
                        begin
                            r = tbgr_pkg::put_gesture(r, tbgr_pkg::GEST_L_SINGLE);
                        end
                        if (cur.right_single_waiting)
                        begin
                            r = tbgr_pkg::put_gesture(r, tbgr_pkg::GEST_R_SINGLE);
                        end
                        s.left_single_waiting  = 1'b0;
                        s.right_single_waiting = 1'b0;
                        s = tbgr_pkg::end_gesture(s);
                    end
                end
            end
            default:
            begin
                s.phase  = tbgr_pkg::PH_IDLE;
                do_start = btn_down;
            end
        endcase

        // new gesture; a pending single of the same button becomes a double
        if (do_start)
        begin
            s.phase          = tbgr_pkg::PH_PRESSED;
            s.elapsed        = '0;
            s.left_involved  = left_pressed;
            s.right_involved = right_pressed;
            s.left_consumed  = 1'b0;
            s.right_consumed = 1'b0;
            s.hold_reported  = 1'b0;
            if (cur.left_single_waiting && left_pressed)
            begin
                s.left_single_waiting = 1'b0;
                r                     = tbgr_pkg::put_gesture(r, tbgr_pkg::GEST_L_DOUBLE);
                s.left_involved       = 1'b0;
                s.left_consumed       = 1'b1;
            end
            if (cur.right_single_waiting && right_pressed)
            begin
                s.right_single_waiting = 1'b0;
                r                      = tbgr_pkg::put_gesture(r, tbgr_pkg::GEST_R_DOUBLE);
                s.right_involved       = 1'b0;
                s.right_consumed       = 1'b1;
            end
        end

        nxt = s;
        res = r;
    end

endmodule

`default_nettype wire

// File: hw/rtl/two_button_gesture_recognizer.sv
// two-button gesture recognizer: single, double, hold and both-button gestures
// input stream: one transaction per sampling tick, s_axis_tdata bit 0 = left
//   level, bit 1 = right level (1 = down); all timing is counted in ticks
// output stream: one transaction per gesture, m_axis_tdata[2:0] = gesture code,
//   m_axis_tlast high on the last gesture caused by a tick; a tick may cause
//   zero, one or two gestures
// config channel: cfg_index 0 simul_ticks, 1 hold_ticks, 2 double_ticks;
//   always ready, write only while no tick is in flight
// path: a tick is captured in the input register, evaluated in one pass
//   once the result register can take its gestures, and they are loaded into
//   the result register, which offers them on the output stream
// throughput: one tick per cycle while each tick gives at most one gesture
//   and m_axis_tready stays high; a tick with two gestures holds the following
//   tick while the two-entry result register drains one gesture per cycle
// stall: when the receiver holds m_axis_tready low, the result register and
//   the input register fill and s_axis_tready drops; nothing is lost
// reset: idle phase, no pending singles, registers back to 8/134/20,
//   both streams empty
`default_nettype none

`include "two_button_gesture_recognizer_defines.svh"

module two_button_gesture_recognizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // left_pressed, right_pressed
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // gesture[2:0]
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tbgr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tbgr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // configuration registers
    tbgr_pkg::cfg_t   cfg_reg;
    // gesture state
    tbgr_pkg::state_t state_reg;
    tbgr_pkg::state_t state_next;
    // input register
    logic             in_valid_reg;
    logic             in_left_reg;
    logic             in_right_reg;
    // result register, up to two gestures of one tick
    tbgr_pkg::res_t   res_reg;
    tbgr_pkg::res_t   res_next;
    tbgr_pkg::res_t   step_res;

    logic             s_fire;
    logic             m_fire;
    logic             step_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.simul_ticks  <= tbgr_pkg::SIMUL_RESET;
            cfg_reg.hold_ticks   <= tbgr_pkg::HOLD_RESET;
            cfg_reg.double_ticks <= tbgr_pkg::DOUBLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // writes to an unlisted index are dropped
            unique case (cfg_index)
                tbgr_pkg::REG_SIMUL_TICKS:
                begin
                    cfg_reg.simul_ticks <= cfg_data[tbgr_pkg::SIMUL_BITS-1:0];
                end
                tbgr_pkg::REG_HOLD_TICKS:
                begin
                    cfg_reg.hold_ticks <= cfg_data[tbgr_pkg::HOLD_BITS-1:0];
                end
                tbgr_pkg::REG_DOUBLE_TICKS:
                begin
                    cfg_reg.double_ticks <= cfg_data[tbgr_pkg::DOUBLE_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_fire = m_axis_tvalid && m_axis_tready;

    // evaluate the held tick once the result register is empty or empties now
    assign step_fire = in_valid_reg &&
                       ((res_reg.cnt == 2'd0) || ((res_reg.cnt == 2'd1) && m_fire));

    assign s_axis_tready = !in_valid_reg || step_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_left_reg  <= s_axis_tdata[0];
            in_right_reg <= s_axis_tdata[1];
        end
    end

    tbgr_step u_step
    (
        .cur           (state_reg),
        .cfg           (cfg_reg),
        .left_pressed  (in_left_reg),
        .right_pressed (in_right_reg),
        .nxt           (state_next),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: tbgr_pkg::PH_IDLE, default: '0};
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register: load a new pair, or shift out one gesture
    always_comb
    begin
        res_next = res_reg;
        if (step_fire)
        begin
            res_next = step_res;
        end
        else if (m_fire)
        begin
            res_next.g0  = res_reg.g1;
            res_next.cnt = res_reg.cnt - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '{cnt: 2'd0, g0: tbgr_pkg::GEST_L_SINGLE, g1: tbgr_pkg::GEST_L_SINGLE};
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = (res_reg.cnt != 2'd0);
    assign m_axis_tdata  = {5'd0, res_reg.g0};
    // the head is the last gesture of its tick when it is alone
    assign m_axis_tlast  = (res_reg.cnt == 2'd1);

    // result register never holds more than one tick's worth
    `TBGR_ASSERT_IMPLIES(a_res_cnt_range, clk, rst_n, 1'b1, res_reg.cnt != 2'd3)

    // a tick is only evaluated when its gestures cannot overwrite waiting ones
    `TBGR_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, step_fire,
                         (res_reg.cnt == 2'd0) || m_fire)

    // a two-gesture tick shows a non-last gesture first
    `TBGR_ASSERT_NEXT(a_pair_order, clk, rst_n, step_fire && (step_res.cnt == 2'd2),
                      m_axis_tvalid && !m_axis_tlast)

endmodule

`default_nettype wire

// File: tb/sv/gesture_checker.sv
module gesture_checker
    import tbgr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,  // left_pressed, right_pressed
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [7:0]                m_axis_tdata,  // gesture[2:0]
    input  logic                      m_axis_tlast,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        fail_count,
    output int                        expected_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        gesture_t code;
        logic     last;
    } gesture_note_t;

    gesture_note_t gesture_q[$];
    gesture_t      tick_gestures[$];

    // timing registers as last written
    logic [SIMUL_BITS-1:0]      simul_lim;
    logic [HOLD_BITS-1:0]       hold_lim;
    logic [DOUBLE_BITS-1:0]     double_lim;

    phase_t                     phase;
    logic [TICK_COUNT_BITS-1:0] elapsed;
    logic                       left_in;
    logic                       right_in;
    logic                       left_used;
    logic                       right_used;
    logic                       hold_seen;
    logic                       left_pending;
    logic                       right_pending;
    int                         mismatches = 0;

    function automatic void count_tick();
        if (elapsed != '1)
        begin
            elapsed++;
        end
    endfunction

    function automatic void close_gesture();
        phase      = PH_IDLE;
        left_in    = 1'b0;
        right_in   = 1'b0;
        left_used  = 1'b0;
        right_used = 1'b0;
        hold_seen  = 1'b0;
    endfunction

    function automatic void open_gesture(logic l, logic r);
        phase      = PH_PRESSED;
        elapsed    = '0;
        left_in    = l;
        right_in   = r;
        left_used  = 1'b0;
        right_used = 1'b0;
        hold_seen  = 1'b0;
        // a press of a button with a pending single turns it into a double
        if (left_pending && l)
        begin
            left_pending = 1'b0;
            tick_gestures.push_back(GEST_L_DOUBLE);
            left_in   = 1'b0;
            left_used = 1'b1;
        end
        if (right_pending && r)
        begin
            right_pending = 1'b0;
            tick_gestures.push_back(GEST_R_DOUBLE);
            right_in   = 1'b0;
            right_used = 1'b1;
        end
    endfunction

    function automatic void predict_gestures(logic l, logic r);
        logic          any;
        gesture_note_t note;
        any = l | r;
        tick_gestures.delete();
        case (phase)
            PH_PRESSED:
            begin
                count_tick();
                if (elapsed <= simul_lim)
                begin
                    if (l && !left_used)
                        left_in = 1'b1;
                    if (r && !right_used)
                        right_in = 1'b1;
                end
                if (any)
                begin
                    if (!hold_seen && elapsed >= hold_lim)
                    begin
                        // marked even when no button is latched
                        hold_seen = 1'b1;
                        if (left_in && right_in)
                            tick_gestures.push_back(GEST_BOTH_HOLD);
                        else if (left_in)
                            tick_gestures.push_back(GEST_L_HOLD);
                        else if (right_in)
                            tick_gestures.push_back(GEST_R_HOLD);
                    end
                end
                else if (hold_seen)
                begin
                    close_gesture();
                end
                else if (left_in && right_in)
                begin
                    tick_gestures.push_back(GEST_BOTH_PRESS);
                    close_gesture();
                end
                else
                begin
                    if (left_in)
                        left_pending = 1'b1;
                    if (right_in)
                        right_pending = 1'b1;
                    phase    = PH_WAIT;
                    elapsed  = '0;
                    left_in  = 1'b0;
                    right_in = 1'b0;
                end
            end
            PH_WAIT:
            begin
                if (any)
                begin
                    open_gesture(l, r);
                end
                else
                begin
                    count_tick();
                    if (elapsed >= double_lim)
                    begin
                        if (left_pending)
                        begin
                            left_pending = 1'b0;
                            tick_gestures.push_back(GEST_L_SINGLE);
                        end
                        if (right_pending)
                        begin
                            right_pending = 1'b0;
                            tick_gestures.push_back(GEST_R_SINGLE);
                        end
                        close_gesture();
                    end
                end
            end
            default:
            begin
                phase = PH_IDLE;
                if (any)
                    open_gesture(l, r);
            end
        endcase
        foreach (tick_gestures[i])
        begin
            note.code = tick_gestures[i];
            note.last = (i == tick_gestures.size() - 1);
            gesture_q.push_back(note);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gesture_note_t want;
        if (!rst_n)
        begin
            simul_lim     = SIMUL_RESET;
            hold_lim      = HOLD_RESET;
            double_lim    = DOUBLE_RESET;
            phase         = PH_IDLE;
            elapsed       = '0;
            left_in       = 1'b0;
            right_in      = 1'b0;
            left_used     = 1'b0;
            right_used    = 1'b0;
            hold_seen     = 1'b0;
            left_pending  = 1'b0;
            right_pending = 1'b0;
            gesture_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIMUL_TICKS:  simul_lim  = cfg_data[SIMUL_BITS-1:0];
                    REG_HOLD_TICKS:   hold_lim   = cfg_data[HOLD_BITS-1:0];
                    REG_DOUBLE_TICKS: double_lim = cfg_data[DOUBLE_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_gestures(s_axis_tdata[0], s_axis_tdata[1]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (gesture_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected gesture, expected none, actual %0d last %0b",
                             $time, m_axis_tdata[2:0], m_axis_tlast);
                end
                else
                begin
                    want = gesture_q.pop_front();
                    if (m_axis_tdata[2:0] !== want.code)
                    begin
                        mismatches++;
                        $display("%0t: gesture mismatch, expected %0d, actual %0d",
                                 $time, want.code, m_axis_tdata[2:0]);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: tlast mismatch, expected %0b, actual %0b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end
        end
        fail_count     <= mismatches;
        expected_count <= gesture_q.size();
    end

endmodule

// File: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbgr_pkg::*;

    // cycles without any transaction before the run is declared hung
    localparam int QUIET_LIMIT = 4000;
    // cycles the receiver holds off once to back the block up
    localparam int SQUEEZE_CYCLES = 400;
    // settle time before a register write, covers the two-stage pipe
    localparam int SETTLE_CYCLES = 8;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;  // left_pressed, right_pressed
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;       // gesture[2:0]
    logic                      m_axis_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    int fail_count;
    int expected_count;

    // timing currently programmed, used to aim press and release lengths
    int cur_simul  = SIMUL_RESET;
    int cur_hold   = HOLD_RESET;
    int cur_double = DOUBLE_RESET;

    int ticks_offered = 0;
    bit src_gaps      = 1'b1;
    bit sink_stalls   = 1'b1;
    bit squeeze_req   = 1'b0;
    bit squeeze_done  = 1'b0;

    two_button_gesture_recognizer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gesture_checker gesture_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .expected_count (expected_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // idle length for either side: mostly none or short, now and then long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // a count of ticks that lands short, right on a threshold or past it
    function automatic int around(int thr);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 3);
            1:       return (thr > 1) ? thr - 1 + $urandom_range(0, 2) : 1 + $urandom_range(0, 2);
            2:       return $urandom_range(1, thr + 3);
            default: return thr + $urandom_range(1, 4);
        endcase
    endfunction

    // press lengths: near the hold boundary when that is affordable,
    // otherwise around the simultaneity window
    function automatic int press_ticks();
        if (cur_hold <= 160 && $urandom_range(0, 3) == 0)
            return around(cur_hold + 1);
        return around(cur_simul + 2);
    endfunction

    // one sampling tick as one input transaction, then an optional gap
    task automatic sample_buttons(input logic l, input logic r);
        int gap;
        s_axis_tdata  <= {6'b0, r, l};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        ticks_offered++;
        gap = src_gaps ? idle_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // L left, R right, B both, anything else released
    task automatic play_levels(input string levels);
        byte c;
        for (int i = 0; i < levels.len(); i++)
        begin
            c = levels[i];
            sample_buttons(c == "L" || c == "B", c == "R" || c == "B");
        end
    endtask

    task automatic write_timing_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // registers change only with the pipe empty: every expected gesture out,
    // then a few cycles so a tick that gave no gesture has left the block too
    task automatic set_timing(input int simul, input int hold, input int dbl);
        s_axis_tvalid <= 1'b0;
        while (expected_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_timing_reg(REG_SIMUL_TICKS, simul);
        write_timing_reg(REG_HOLD_TICKS, hold);
        write_timing_reg(REG_DOUBLE_TICKS, dbl);
        cfg_valid  <= 1'b0;
        cur_simul  = simul;
        cur_hold   = hold;
        cur_double = dbl;
        // idle pattern for the coming phase, sometimes none at all
        src_gaps    = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
    endtask

    // mostly well-formed gestures with random timing, some noise
    task automatic random_gestures(input int budget);
        int   start;
        int   kind;
        int   who;
        int   d;
        int   la;
        int   lb;
        int   n;
        int   rest;
        logic a;
        logic b;
        start = ticks_offered;
        while (ticks_offered - start < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                // arbitrary levels, breaks gestures at odd points
                repeat ($urandom_range(1, 8))
                    sample_buttons($urandom_range(0, 1), $urandom_range(0, 1));
            end
            else
            begin
                // 0 left, 1 right, 2 both at once, 3 left then right,
                // 4 right then left; second button joins near the window edge
                who = $urandom_range(0, 4);
                la  = press_ticks();
                lb  = press_ticks();
                d   = (who == 2) ? 0 : around(cur_simul + 1) - 1;
                n   = (who < 2) ? la : ((la > d + lb) ? la : d + lb);
                for (int i = 0; i < n; i++)
                begin
                    a = (i < la);
                    b = (who >= 2) && (i >= d) && (i < d + lb);
                    if (who == 1 || who == 4)
                        sample_buttons(b, a);
                    else
                        sample_buttons(a, b);
                end
                // release length straddles the double window
                rest = around(cur_double + 1);
                repeat (rest) sample_buttons(1'b0, 1'b0);
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short timing so every gesture fits in a few ticks
        set_timing(1, 2, 2);
        // two pending singles both turned into doubles by one press,
        // right hold, both hold, both press by a late join, left hold,
        // two singles out on one tick, a hold on a consumed button alone
        play_levels("L-R-B-RRR-BBB-LR-LLL-L-R---L-LLL-");
        random_gestures(80);

        // tight timing: gestures nearly every few ticks; the
        // receiver holds off meanwhile so the block backs up
        set_timing(0, 1, 1);
        src_gaps    = 1'b0;
        squeeze_req = 1'b1;
        random_gestures(150);

        // zero hold and double windows fire on the first tick of a phase
        set_timing(0, 0, 0);
        random_gestures(60);

        set_timing(SIMUL_RESET, HOLD_RESET, DOUBLE_RESET);
        random_gestures(60);

        // widest timing; one press long enough to hit the largest hold and
        // run the tick counter into saturation
        set_timing(255, 1023, 255);
        repeat (1030) sample_buttons(1'b1, 1'b1);
        random_gestures(1);

        repeat (2)
        begin
            set_timing($urandom_range(0, 12), $urandom_range(1, 40), $urandom_range(1, 15));
            random_gestures(60);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_count == 0 && !m_axis_tvalid)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // receiver: ready in random stretches, with one long hold-off on request
    initial
    begin : result_sink
        int busy;
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_done = 1'b1;
            end
            m_axis_tready <= 1'b1;
            busy = $urandom_range(1, 24);
            repeat (busy) @(posedge clk);
            stall = sink_stalls ? idle_len() : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // ends a hung run: counts cycles with no transaction on any channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
